### rtl/hpcg_pkg.sv
// Package for the hue palette color generator.
// Holds widths, register indexes, scheme codes and the divider payload type.
// No dependencies.
package hpcg_pkg;

    localparam int MAX_PALETTE = 4096;

    localparam int IDX_W  = 12;              // index field and palette_size - 1
    localparam int SIZE_W = 13;              // palette_size register
    localparam int CFG_W  = 13;              // widest configuration register
    localparam int COL_W  = 8;               // one color channel
    localparam int FRAC_W = 8;               // fraction bits of hue times six
    localparam int QUO_W  = 11;              // quotient bits, hue*6*256 <= 1536
    localparam int NUM_W  = 15;              // scaled index, up to 6 * 4095
    localparam int DVD_W  = NUM_W + FRAC_W;  // dividend width

    // Configuration register indexes
    localparam logic REG_SCHEME   = 1'b0;
    localparam logic REG_PAL_SIZE = 1'b1;

    // Scheme codes; anything else runs the full hue wheel
    localparam logic [1:0] SCH_RED_BLUE = 2'd0;
    localparam logic [1:0] SCH_BLUE_RED = 2'd1;
    localparam logic [1:0] SCH_WHEEL    = 2'd2;

    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(256);

    // Partial remainder, dividend bits still to enter with quotient bits
    // shifted in at the bottom, and the clamp flag riding along.
    typedef struct packed {
        logic [IDX_W-1:0] rem;
        logic [QUO_W-1:0] quo;
        logic             clamped;
    } t_div;

endpackage

### rtl/hue_palette_color_generator.sv
// Top level of the hue palette color generator.
// Depends on hpcg_pkg, hpcg_front, hpcg_cell and hpcg_color.
//
// Usage:
//   Input channel: one palette index per beat on i_index, qualified by
//   i_in_valid and held back by o_in_stall. Output channel: o_red, o_green,
//   o_blue and o_index_clamped per beat, qualified by o_out_valid and held
//   back by i_out_stall. Each index yields exactly one color, in order.
//   Configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx
//   (scheme or palette_size); write only while the pipeline is empty.
//   Path: the front stage loads at the accepting edge, then the beat passes
//   11 division cells and the color stage, each registered. Throughput: one
//   beat per cycle while i_out_stall is low; the chain of 11
//   restoring-division cells, one quotient bit each, sets the depth.
//   Reset (synchronous, active low) empties every stage and loads scheme 2
//   (full wheel) and palette_size 256.
//   Stall: each stage advances when its successor is empty or advancing, so
//   under i_out_stall the output holds its beat while bubbles further up
//   close; the input stalls only once every stage is full.
module hue_palette_color_generator (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic                              i_cfg_idx,
    input  logic [hpcg_pkg::CFG_W-1:0]        i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [hpcg_pkg::IDX_W-1:0]        i_index,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [hpcg_pkg::COL_W-1:0]        o_red,
    output logic [hpcg_pkg::COL_W-1:0]        o_green,
    output logic [hpcg_pkg::COL_W-1:0]        o_blue,
    output logic                              o_index_clamped
);

    logic [1:0]                     r_scheme;
    logic [hpcg_pkg::IDX_W-1:0]     r_div;      // palette_size - 1
    logic [hpcg_pkg::SIZE_W-1:0]    n_size;
    logic [hpcg_pkg::IDX_W-1:0]     n_div;

    // Stage links: entry 0 is the front stage output, entry k the k-th cell
    logic           link_valid [hpcg_pkg::QUO_W+1];
    logic           link_ready [hpcg_pkg::QUO_W+1];
    hpcg_pkg::t_div link_data  [hpcg_pkg::QUO_W+1];
    logic           front_ready;

    // Clamp palette_size into [2, MAX_PALETTE] and keep palette_size - 1 as the divisor
    always_comb begin
        n_size = i_cfg_data[hpcg_pkg::SIZE_W-1:0];
        if (n_size < hpcg_pkg::SIZE_W'(2)) begin
            n_size = hpcg_pkg::SIZE_W'(2);
        end
        if (n_size > hpcg_pkg::SIZE_W'(hpcg_pkg::MAX_PALETTE)) begin
            n_size = hpcg_pkg::SIZE_W'(hpcg_pkg::MAX_PALETTE);
        end
        n_div = hpcg_pkg::IDX_W'(n_size - hpcg_pkg::SIZE_W'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scheme <= hpcg_pkg::SCH_WHEEL;
            r_div    <= hpcg_pkg::IDX_W'(hpcg_pkg::SIZE_RESET - hpcg_pkg::SIZE_W'(1));
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                hpcg_pkg::REG_SCHEME:   r_scheme <= i_cfg_data[1:0];
                hpcg_pkg::REG_PAL_SIZE: r_div    <= n_div;
                default:                r_scheme <= r_scheme;
            endcase
        end
    end

    assign o_in_stall = !front_ready;

    // Clamp and scale the index, load the dividend
    hpcg_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in_valid),
        .o_ready  (front_ready),
        .i_index  (i_index),
        .i_scheme (r_scheme),
        .i_div    (r_div),
        .o_valid  (link_valid[0]),
        .i_ready  (link_ready[0]),
        .o_data   (link_data[0])
    );

    // Division chain: each cell retires one quotient bit and hands on
    for (genvar k = 0; k < hpcg_pkg::QUO_W; k++) begin : g_cell
        hpcg_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (link_valid[k]),
            .o_ready (link_ready[k]),
            .i_data  (link_data[k]),
            .i_div   (r_div),
            .o_valid (link_valid[k+1]),
            .i_ready (link_ready[k+1]),
            .o_data  (link_data[k+1])
        );
    end

    // Map sector and fraction to RGB, hold the beat for the receiver
    hpcg_color u_color (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (link_valid[hpcg_pkg::QUO_W]),
        .o_ready   (link_ready[hpcg_pkg::QUO_W]),
        .i_data    (link_data[hpcg_pkg::QUO_W]),
        .o_valid   (o_out_valid),
        .i_stall   (i_out_stall),
        .o_red     (o_red),
        .o_green   (o_green),
        .o_blue    (o_blue),
        .o_clamped (o_index_clamped)
    );

endmodule

### rtl/hpcg_front.sv
// Front stage: clamps the index, scales it by the scheme and loads the divider.
// Depends on hpcg_pkg.
module hpcg_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [hpcg_pkg::IDX_W-1:0]   i_index,
    input  logic [1:0]                   i_scheme,
    input  logic [hpcg_pkg::IDX_W-1:0]   i_div,
    output logic                         o_valid,
    input  logic                         i_ready,
    output hpcg_pkg::t_div               o_data
);

    logic                         r_valid;
    hpcg_pkg::t_div               r_data;
    hpcg_pkg::t_div               n_data;
    logic                         over;
    logic [hpcg_pkg::IDX_W-1:0]   idx;
    logic [hpcg_pkg::IDX_W-1:0]   rev;
    logic [hpcg_pkg::NUM_W-1:0]   num;
    logic [hpcg_pkg::DVD_W-1:0]   dvd;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_comb begin
        over = i_index > i_div;
        idx  = over ? i_div : i_index;
        rev  = i_div - idx;
        case (i_scheme)
            hpcg_pkg::SCH_RED_BLUE: num = {1'b0, idx, 2'b00};
            hpcg_pkg::SCH_BLUE_RED: num = {1'b0, rev, 2'b00};
            default:                num = {1'b0, idx, 2'b00} + {2'b00, idx, 1'b0};
        endcase
        dvd            = {num, {hpcg_pkg::FRAC_W{1'b0}}};
        // quotient fits in QUO_W bits, so the top bits already sit below the divisor
        n_data.rem     = dvd[hpcg_pkg::DVD_W-1 -: hpcg_pkg::IDX_W];
        n_data.quo     = dvd[hpcg_pkg::QUO_W-1:0];
        n_data.clamped = over;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

### rtl/hpcg_cell.sv
// One restoring-division cell: retires one quotient bit per beat.
// Depends on hpcg_pkg.
module hpcg_cell (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  hpcg_pkg::t_div               i_data,
    input  logic [hpcg_pkg::IDX_W-1:0]   i_div,
    output logic                         o_valid,
    input  logic                         i_ready,
    output hpcg_pkg::t_div               o_data
);

    logic                         r_valid;
    hpcg_pkg::t_div               r_data;
    hpcg_pkg::t_div               n_data;
    logic [hpcg_pkg::IDX_W:0]     trial;
    logic [hpcg_pkg::IDX_W:0]     diff;
    logic                         fits;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_comb begin
        // bring down the next dividend bit, subtract if the divisor fits
        trial          = {i_data.rem, i_data.quo[hpcg_pkg::QUO_W-1]};
        diff           = trial - {1'b0, i_div};
        fits           = trial >= {1'b0, i_div};
        n_data.rem     = fits ? diff[hpcg_pkg::IDX_W-1:0] : trial[hpcg_pkg::IDX_W-1:0];
        n_data.quo     = {i_data.quo[hpcg_pkg::QUO_W-2:0], fits};
        n_data.clamped = i_data.clamped;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

### rtl/hpcg_color.sv
// Output stage: maps hue sector and fraction to RGB and holds the result beat.
// Depends on hpcg_pkg.
module hpcg_color (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  hpcg_pkg::t_div               i_data,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [hpcg_pkg::COL_W-1:0]   o_red,
    output logic [hpcg_pkg::COL_W-1:0]   o_green,
    output logic [hpcg_pkg::COL_W-1:0]   o_blue,
    output logic                         o_clamped
);

    localparam logic [hpcg_pkg::COL_W-1:0] FULL = '1;
    localparam logic [hpcg_pkg::COL_W-1:0] NONE = '0;

    logic                         r_valid;
    logic [hpcg_pkg::COL_W-1:0]   r_red;
    logic [hpcg_pkg::COL_W-1:0]   r_green;
    logic [hpcg_pkg::COL_W-1:0]   r_blue;
    logic                         r_clamped;
    logic [hpcg_pkg::COL_W-1:0]   n_red;
    logic [hpcg_pkg::COL_W-1:0]   n_green;
    logic [hpcg_pkg::COL_W-1:0]   n_blue;
    logic [2:0]                   sector;
    logic [hpcg_pkg::COL_W-1:0]   up;
    logic [hpcg_pkg::COL_W-1:0]   down;

    assign o_ready   = !r_valid || !i_stall;
    assign o_valid   = r_valid;
    assign o_red     = r_red;
    assign o_green   = r_green;
    assign o_blue    = r_blue;
    assign o_clamped = r_clamped;

    always_comb begin
        sector = i_data.quo[hpcg_pkg::QUO_W-1:hpcg_pkg::FRAC_W];
        up     = i_data.quo[hpcg_pkg::FRAC_W-1:0];
        down   = FULL - up;
        // sector six (top of the wheel) wraps to red like sector zero
        case (sector)
            3'd1:    begin n_red = down; n_green = FULL; n_blue = NONE; end
            3'd2:    begin n_red = NONE; n_green = FULL; n_blue = up;   end
            3'd3:    begin n_red = NONE; n_green = down; n_blue = FULL; end
            3'd4:    begin n_red = up;   n_green = NONE; n_blue = FULL; end
            3'd5:    begin n_red = FULL; n_green = NONE; n_blue = down; end
            default: begin n_red = FULL; n_green = up;   n_blue = NONE; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_red     <= n_red;
            r_green   <= n_green;
            r_blue    <= n_blue;
            r_clamped <= i_data.clamped;
        end
    end

endmodule

### sim/hue_palette_color_generator_tb.sv
// Testbench for hue_palette_color_generator: drives palette indexes and checks the
// colors against a predictor of the HSV rainbow mapping, across register settings.
// Depends on hpcg_pkg and the hue_palette_color_generator RTL.
module hue_palette_color_generator_tb;

    // Cycles with no accepted beat before the run is declared hung
    localparam int HANG_LIMIT  = 4000;
    // Settle time after the last color
    localparam int SETTLE_CYCLES = 20;

    typedef struct {
        logic [hpcg_pkg::COL_W-1:0] red;
        logic [hpcg_pkg::COL_W-1:0] green;
        logic [hpcg_pkg::COL_W-1:0] blue;
        logic                       clamped;
    } t_color;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          i_cfg_we;
    logic                          i_cfg_idx;
    logic [hpcg_pkg::CFG_W-1:0]    i_cfg_data;
    logic                          i_in_valid;
    logic                          o_in_stall;
    logic [hpcg_pkg::IDX_W-1:0]    i_index;
    logic                          o_out_valid;
    logic                          i_out_stall;
    logic [hpcg_pkg::COL_W-1:0]    o_red;
    logic [hpcg_pkg::COL_W-1:0]    o_green;
    logic [hpcg_pkg::COL_W-1:0]    o_blue;
    logic                          o_index_clamped;

    // Shadow copy of the two registers, as the block should hold them
    logic [1:0]                    scheme_sel = hpcg_pkg::SCH_WHEEL;
    logic [hpcg_pkg::SIZE_W-1:0]   pal_size   = hpcg_pkg::SIZE_RESET;

    t_color              pending_colors[$];
    int                  error_count = 0;
    int                  hang_count  = 0;
    bit                  idling      = 1'b0;

    hue_palette_color_generator dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_index         (i_index),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_red           (o_red),
        .o_green         (o_green),
        .o_blue          (o_blue),
        .o_index_clamped (o_index_clamped)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Work out the color of one palette entry from the shadow registers.
    // Scaled hue (times six on the wheel, times four in the two ramp schemes)
    // is a truncated quotient with 8 fraction bits; the integer part picks the
    // sector (a full turn wraps back to red), the fraction drives the ramping channel.
    function automatic t_color rainbow_color(logic [hpcg_pkg::IDX_W-1:0] idx);
        int unsigned span, pos, num, quo, sector;
        logic [hpcg_pkg::COL_W-1:0] up, down;
        t_color c;
        span = pal_size - 1;
        pos = idx;
        c.clamped = 1'b0;
        if (pos > span) begin
            pos = span;
            c.clamped = 1'b1;
        end
        case (scheme_sel)
            hpcg_pkg::SCH_RED_BLUE: num = 4 * pos;
            hpcg_pkg::SCH_BLUE_RED: num = 4 * (span - pos);
            default:                num = 6 * pos;   // wheel, and the unused code too
        endcase
        quo = (num << hpcg_pkg::FRAC_W) / span;
        sector = (quo >> hpcg_pkg::FRAC_W) % 6;
        up = quo[hpcg_pkg::COL_W-1:0];
        down = 8'd255 - up;
        case (sector)
            0: begin c.red = 8'd255; c.green = up;     c.blue = 8'd0;   end
            1: begin c.red = down;   c.green = 8'd255; c.blue = 8'd0;   end
            2: begin c.red = 8'd0;   c.green = 8'd255; c.blue = up;     end
            3: begin c.red = 8'd0;   c.green = down;   c.blue = 8'd255; end
            4: begin c.red = up;     c.green = 8'd0;   c.blue = 8'd255; end
            default: begin c.red = 8'd255; c.green = 8'd0; c.blue = down; end
        endcase
        return c;
    endfunction

    // Send one index beat. Valid stays high after acceptance so that
    // back-to-back beats run at full rate; a gap or a drain lowers it.
    task automatic send_index(input logic [hpcg_pkg::IDX_W-1:0] idx);
        if (idling && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_index    <= idx;
        do @(posedge i_clk); while (o_in_stall);
        pending_colors = {pending_colors, rainbow_color(idx)};
    endtask

    // Drop valid and hold until every expected color is out and the pipe
    // has had time to empty.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_colors.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write one register while the block is idle and mirror the write,
    // including the clamping of palette_size into 2..MAX_PALETTE.
    task automatic write_reg(input logic idx, input logic [hpcg_pkg::CFG_W-1:0] data);
        wait_drained();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == hpcg_pkg::REG_SCHEME) begin
            scheme_sel = data[1:0];
        end else if (data < 2) begin
            pal_size = hpcg_pkg::SIZE_W'(2);
        end else if (data > hpcg_pkg::MAX_PALETTE) begin
            pal_size = hpcg_pkg::SIZE_W'(hpcg_pkg::MAX_PALETTE);
        end else begin
            pal_size = data;
        end
    endtask

    // Mostly in-range entries, some past the end, some anywhere in 12 bits
    function automatic logic [hpcg_pkg::IDX_W-1:0] pick_index();
        int unsigned top;
        top = (pal_size > 4095) ? 4095 : pal_size;
        case ($urandom_range(0, 9))
            0: return hpcg_pkg::IDX_W'($urandom);
            1: begin
                case ($urandom_range(0, 3))
                    0: return '0;
                    1: return '1;
                    2: return hpcg_pkg::IDX_W'(pal_size - 1);
                    default: return hpcg_pkg::IDX_W'(top);
                endcase
            end
            default: return hpcg_pkg::IDX_W'($urandom_range(0, pal_size - 1));
        endcase
    endfunction

    // Mostly sizes anywhere in the full range, small palettes often, out-of-range writes now and then
    function automatic logic [hpcg_pkg::CFG_W-1:0] pick_size();
        logic [hpcg_pkg::CFG_W-1:0] odd_sizes[7] = '{0, 1, 2, 3, 4096, 4097, 8191};
        case ($urandom_range(0, 9))
            0: return hpcg_pkg::CFG_W'($urandom);
            1: return odd_sizes[$urandom_range(0, 6)];
            2, 3, 4: return hpcg_pkg::CFG_W'($urandom_range(2, 16));
            default: return hpcg_pkg::CFG_W'($urandom_range(2, hpcg_pkg::MAX_PALETTE));
        endcase
    endfunction

    // Reset palette: full wheel over 256 entries, top entry wraps to red,
    // indexes past the end clamp.
    task automatic test_default_palette();
        send_index(12'd0);
        send_index(12'd128);
        send_index(12'd255);
        send_index(12'd256);
        send_index(12'd4095);
    endtask

    // Register corners: sizes below 2 and above the maximum, every scheme
    // code including the unused one, scheme data with high garbage bits.
    task automatic test_register_corners();
        write_reg(hpcg_pkg::REG_SCHEME, hpcg_pkg::CFG_W'(hpcg_pkg::SCH_RED_BLUE) | 13'h1FFC);
        write_reg(hpcg_pkg::REG_PAL_SIZE, 13'd0);
        send_index(12'd0);
        send_index(12'd1);
        send_index(12'd4095);
        write_reg(hpcg_pkg::REG_SCHEME, hpcg_pkg::CFG_W'(hpcg_pkg::SCH_BLUE_RED));
        write_reg(hpcg_pkg::REG_PAL_SIZE, 13'd1);
        send_index(12'd0);
        send_index(12'd1);
        write_reg(hpcg_pkg::REG_SCHEME, 13'd3);
        write_reg(hpcg_pkg::REG_PAL_SIZE, 13'h1FFF);
        send_index(12'd4095);
        send_index(12'd2048);
        send_index(12'd0);
        write_reg(hpcg_pkg::REG_SCHEME, hpcg_pkg::CFG_W'(hpcg_pkg::SCH_WHEEL));
        write_reg(hpcg_pkg::REG_PAL_SIZE, 13'd4097);
        send_index(12'd4095);
    endtask

    // Random phases: new registers, then a run of random indexes
    task automatic test_random_phases(input int phases, input int beats, input bit idle_on);
        for (int p = 0; p < phases; p++) begin
            write_reg(hpcg_pkg::REG_SCHEME, hpcg_pkg::CFG_W'($urandom));
            write_reg(hpcg_pkg::REG_PAL_SIZE, pick_size());
            // leave some phases without any idling
            idling = idle_on && ($urandom_range(0, 3) != 0);
            for (int k = 0; k < beats; k++) send_index(pick_index());
        end
    endtask

    // Hold the sender until the pipeline is empty, then resume
    task automatic test_pause_for_drain();
        idling = 1'b1;
        for (int k = 0; k < 40; k++) send_index(pick_index());
        wait_drained();
        for (int k = 0; k < 40; k++) send_index(pick_index());
    endtask

    initial begin
        i_rst_n    <= 1'b0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= hpcg_pkg::REG_SCHEME;
        i_cfg_data <= '0;
        i_in_valid <= 1'b0;
        i_index    <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_palette();
        test_register_corners();
        test_random_phases(12, 115, 1'b1);
        test_pause_for_drain();
        // last stretch at full rate on both sides
        test_random_phases(2, 140, 1'b0);

        wait_drained();
        if (error_count == 0) begin
            $display("[hue_palette_color_generator] OK");
        end else begin
            $display("[hue_palette_color_generator] ERROR");
        end
        $finish;
    end

    // Output stall in random bursts while idling is on
    initial begin
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (idling && $urandom_range(0, 7) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 18)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    // Check each accepted color against the oldest prediction, and watch
    // for a hang: too many cycles with no beat accepted on either side.
    always @(posedge i_clk) begin
        t_color want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_colors.size() == 0) begin
                $error("color beat with nothing expected: r=%0d g=%0d b=%0d",
                       o_red, o_green, o_blue);
                error_count++;
            end else begin
                want = pending_colors.pop_front();
                if (o_red !== want.red) begin
                    $error("red: expected %0d, got %0d", want.red, o_red);
                    error_count++;
                end
                if (o_green !== want.green) begin
                    $error("green: expected %0d, got %0d", want.green, o_green);
                    error_count++;
                end
                if (o_blue !== want.blue) begin
                    $error("blue: expected %0d, got %0d", want.blue, o_blue);
                    error_count++;
                end
                if (o_index_clamped !== want.clamped) begin
                    $error("index_clamped: expected %0d, got %0d",
                           want.clamped, o_index_clamped);
                    error_count++;
                end
            end
        end

        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            hang_count = 0;
        end else begin
            hang_count++;
        end
        if (hang_count >= HANG_LIMIT) begin
            $display("[hue_palette_color_generator] ERROR");
            $finish;
        end
    end

endmodule
